// ===== src/ccr2d_pkg.sv =====
// Package for the 2-D cross-correlation block: field widths, action codes,
// register indexes and the control word handed to the multiply-accumulate unit.
// No dependencies.
package ccr2d_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int PROD_W    = 32;
	localparam int SUM_W     = 38;
	localparam int POS_IN_W  = 6;
	localparam int IMG_CFG_W = 6;
	localparam int KER_CFG_W = 4;
	localparam int CFG_AW    = 5;
	localparam int CFG_DW    = 32;

	localparam int DEF_MAX_IMAGE_SIDE  = 32;
	localparam int DEF_MAX_KERNEL_SIDE = 8;

	localparam logic [1:0] ACT_KERNEL  = 2'd0;
	localparam logic [1:0] ACT_IMAGE   = 2'd1;
	localparam logic [1:0] ACT_REQUEST = 2'd2;

	localparam logic [2:0] REG_IMAGE_ROWS  = 3'd0;
	localparam logic [2:0] REG_IMAGE_COLS  = 3'd1;
	localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
	localparam logic [2:0] REG_KERNEL_COLS = 3'd3;
	localparam logic [2:0] REG_FULL_MODE   = 3'd4;

	typedef struct packed {
		logic valid;
		logic clear;
		logic keep;
		logic last;
	} mac_ctl_t;

endpackage

// ===== src/ccr2d_mac.sv =====
// Multiply-accumulate pipeline: product register, then 38-bit wrapping accumulator.
// Control word arrives with the memory read addresses; data in the cycle after.
// Depends on ccr2d_pkg.
module ccr2d_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  ccr2d_pkg::mac_ctl_t                     ctl,
	input  logic signed [ccr2d_pkg::SAMPLE_W-1:0]   kdata,
	input  logic signed [ccr2d_pkg::SAMPLE_W-1:0]   idata,
	output logic signed [ccr2d_pkg::SUM_W-1:0]      acc,
	output logic                                    done
);
	import ccr2d_pkg::*;

	mac_ctl_t                   ctl_s1;
	mac_ctl_t                   ctl_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [SUM_W-1:0]    acc_q;
	logic                       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ctl_s1.keep ? PROD_W'(kdata * idata) : '0;
		if (ctl_s2.valid) begin
			acc_q <= (ctl_s2.clear ? '0 : acc_q) + SUM_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== src/cross_correlate_2d_top.sv =====
// 2-D cross-correlation, valid or full mode, over an image and a kernel held in
// synchronous memories. Writes leave the block free; a request occupies it while
// its kernel taps run (one kernel tap read from both memories per cycle through
// the single MAC) until its sum is registered for output; out of range, no taps run.
// Reset clears control state and loads register defaults; memory contents are
// undefined until written. Depends on ccr2d_pkg and ccr2d_mac.
module cross_correlate_2d_top #(
	parameter int MAX_IMAGE_SIDE  = ccr2d_pkg::DEF_MAX_IMAGE_SIDE,
	parameter int MAX_KERNEL_SIDE = ccr2d_pkg::DEF_MAX_KERNEL_SIDE
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            action,
	input  logic [ccr2d_pkg::POS_IN_W-1:0]        row,
	input  logic [ccr2d_pkg::POS_IN_W-1:0]        col,
	input  logic signed [ccr2d_pkg::SAMPLE_W-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ccr2d_pkg::SUM_W-1:0]    sum,
	output logic                                  out_of_range,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ccr2d_pkg::CFG_AW-1:0]          paddr,
	input  logic [ccr2d_pkg::CFG_DW-1:0]          pwdata,
	output logic [ccr2d_pkg::CFG_DW-1:0]          prdata,
	output logic                                  pready
);
	import ccr2d_pkg::*;

	localparam int IA_W = $clog2(MAX_IMAGE_SIDE);
	localparam int KA_W = (MAX_KERNEL_SIDE > 1) ? $clog2(MAX_KERNEL_SIDE) : 1;
	localparam int IS_W = $clog2(MAX_IMAGE_SIDE + 1);
	localparam int KS_W = $clog2(MAX_KERNEL_SIDE + 1);
	localparam int IDEPTH = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
	localparam int KDEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
	localparam int IAW = $clog2(IDEPTH);
	localparam int KAW = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
	localparam int PW = $clog2(MAX_IMAGE_SIDE + MAX_KERNEL_SIDE + 64) + 1;
	localparam logic signed [PW-1:0] ONE_P  = PW'(1);
	localparam logic signed [PW-1:0] ZERO_P = '0;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [IMG_CFG_W-1:0] image_rows_q, image_cols_q;
	logic [KER_CFG_W-1:0] kernel_rows_q, kernel_cols_q;
	logic                 full_mode_q;

	logic [1:0]            state_q;
	logic signed [PW-1:0]  row_q, col_q, dr_q, dc_q;
	logic [KA_W-1:0]       a_q, b_q;
	logic                  oor_q;
	logic                  out_valid_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                  out_oor_q;

	logic [IS_W-1:0]       ir, ic;
	logic [KS_W-1:0]       kr, kc;
	logic signed [PW-1:0]  ir_p, ic_p, kr_p, kc_p, row_p, col_p, oh, ow;
	logic signed [PW-1:0]  rr, cc, a_p, b_p;
	logic                  accept, cfg_wr, inb, a_last, b_last, out_free;
	logic                  kwe, iwe;
	logic [KAW-1:0]        kwaddr, kraddr;
	logic [IAW-1:0]        iwaddr, iraddr;
	mac_ctl_t              ctl;
	logic signed [SAMPLE_W-1:0] kdata_s1, idata_s1;
	logic signed [SUM_W-1:0]    mac_acc;
	logic                       mac_done;

	logic [SAMPLE_W-1:0] kmem [KDEPTH];
	logic [SAMPLE_W-1:0] imem [IDEPTH];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q  <= IMG_CFG_W'(28);
			image_cols_q  <= IMG_CFG_W'(28);
			kernel_rows_q <= KER_CFG_W'(3);
			kernel_cols_q <= KER_CFG_W'(3);
			full_mode_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_IMAGE_ROWS:  image_rows_q  <= pwdata[IMG_CFG_W-1:0];
				REG_IMAGE_COLS:  image_cols_q  <= pwdata[IMG_CFG_W-1:0];
				REG_KERNEL_ROWS: kernel_rows_q <= pwdata[KER_CFG_W-1:0];
				REG_KERNEL_COLS: kernel_cols_q <= pwdata[KER_CFG_W-1:0];
				REG_FULL_MODE:   full_mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_IMAGE_ROWS:  prdata = CFG_DW'(image_rows_q);
			REG_IMAGE_COLS:  prdata = CFG_DW'(image_cols_q);
			REG_KERNEL_ROWS: prdata = CFG_DW'(kernel_rows_q);
			REG_KERNEL_COLS: prdata = CFG_DW'(kernel_cols_q);
			REG_FULL_MODE:   prdata = CFG_DW'(full_mode_q);
			default:         prdata = '0;
		endcase
	end

	// saturate sizes in use
	always_comb begin
		if (image_rows_q == '0)                        ir = IS_W'(1);
		else if (32'(image_rows_q) > MAX_IMAGE_SIDE)   ir = IS_W'(MAX_IMAGE_SIDE);
		else                                           ir = IS_W'(image_rows_q);
		if (image_cols_q == '0)                        ic = IS_W'(1);
		else if (32'(image_cols_q) > MAX_IMAGE_SIDE)   ic = IS_W'(MAX_IMAGE_SIDE);
		else                                           ic = IS_W'(image_cols_q);
		if (kernel_rows_q == '0)                       kr = KS_W'(1);
		else if (32'(kernel_rows_q) > MAX_KERNEL_SIDE) kr = KS_W'(MAX_KERNEL_SIDE);
		else                                           kr = KS_W'(kernel_rows_q);
		if (kernel_cols_q == '0)                       kc = KS_W'(1);
		else if (32'(kernel_cols_q) > MAX_KERNEL_SIDE) kc = KS_W'(MAX_KERNEL_SIDE);
		else                                           kc = KS_W'(kernel_cols_q);
	end

	assign ir_p  = $signed({{(PW-IS_W){1'b0}}, ir});
	assign ic_p  = $signed({{(PW-IS_W){1'b0}}, ic});
	assign kr_p  = $signed({{(PW-KS_W){1'b0}}, kr});
	assign kc_p  = $signed({{(PW-KS_W){1'b0}}, kc});
	assign row_p = $signed({{(PW-POS_IN_W){1'b0}}, row});
	assign col_p = $signed({{(PW-POS_IN_W){1'b0}}, col});
	assign oh    = full_mode_q ? (ir_p + kr_p - ONE_P) : (ir_p - kr_p + ONE_P);
	assign ow    = full_mode_q ? (ic_p + kc_p - ONE_P) : (ic_p - kc_p + ONE_P);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign kwe    = accept && (action == ACT_KERNEL) && (row_p < kr_p) && (col_p < kc_p);
	assign iwe    = accept && (action == ACT_IMAGE) && (row_p < ir_p) && (col_p < ic_p);
	assign kwaddr = KAW'(row_p[KA_W-1:0] * MAX_KERNEL_SIDE + col_p[KA_W-1:0]);
	assign iwaddr = IAW'(row_p[IA_W-1:0] * MAX_IMAGE_SIDE + col_p[IA_W-1:0]);

	assign a_p    = $signed({{(PW-KA_W){1'b0}}, a_q});
	assign b_p    = $signed({{(PW-KA_W){1'b0}}, b_q});
	assign rr     = row_q + a_p - dr_q;
	assign cc     = col_q + b_p - dc_q;
	assign inb    = (rr >= ZERO_P) && (rr < ir_p) && (cc >= ZERO_P) && (cc < ic_p);
	assign kraddr = KAW'(a_q * MAX_KERNEL_SIDE + b_q);
	assign iraddr = inb ? IAW'(rr[IA_W-1:0] * MAX_IMAGE_SIDE + cc[IA_W-1:0]) : '0;
	assign a_last = (a_q == KA_W'(kr - KS_W'(1)));
	assign b_last = (b_q == KA_W'(kc - KS_W'(1)));

	always_comb begin
		ctl = '0;
		if (state_q == ST_RUN) begin
			ctl.valid = 1'b1;
			ctl.clear = (a_q == '0) && (b_q == '0);
			ctl.keep  = inb;
			ctl.last  = a_last && b_last;
		end
	end

	always_ff @(posedge clk) begin
		if (kwe) begin
			kmem[kwaddr] <= value;
		end
		kdata_s1 <= kmem[kraddr];
	end

	always_ff @(posedge clk) begin
		if (iwe) begin
			imem[iwaddr] <= value;
		end
		idata_s1 <= imem[iraddr];
	end

	ccr2d_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.kdata  (kdata_s1),
		.idata  (idata_s1),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_q         <= '0;
			b_q         <= '0;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && action == ACT_REQUEST) begin
						a_q   <= '0;
						b_q   <= '0;
						oor_q <= (row_p >= oh) || (col_p >= ow);
						state_q <= ((row_p >= oh) || (col_p >= ow)) ? ST_WAIT : ST_RUN;
					end
				end
				ST_RUN: begin
					if (b_last) begin
						b_q <= '0;
						a_q <= a_q + KA_W'(1);
						if (a_last) begin
							state_q <= ST_FLUSH;
						end
					end else begin
						b_q <= b_q + KA_W'(1);
					end
				end
				ST_FLUSH: begin
					if (mac_done) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_REQUEST) begin
			row_q <= row_p;
			col_q <= col_p;
			dr_q  <= full_mode_q ? (kr_p - ONE_P) : ZERO_P;
			dc_q  <= full_mode_q ? (kc_p - ONE_P) : ZERO_P;
		end
		if (state_q == ST_WAIT && out_free) begin
			sum_q     <= oor_q ? '0 : mac_acc;
			out_oor_q <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sum          = sum_q;
	assign out_of_range = out_oor_q;

endmodule

// ===== src/ccr2d_checker.sv =====
// Port-level checks for the 2-D cross-correlation block, bound to the top level.
// Depends on ccr2d_pkg for action codes and field widths.
module ccr2d_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic [1:0]                            action,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [ccr2d_pkg::SUM_W-1:0]    sum,
	input logic                                  out_of_range
);
	import ccr2d_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> sum == '0)
		else $error("out-of-range result with nonzero sum");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_REQUEST |=> in_stall)
		else $error("request transfer did not occupy the block");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_KERNEL || action == ACT_IMAGE) |=> !in_stall)
		else $error("write transfer left the block busy");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result appeared while a request was still in work");

endmodule

bind cross_correlate_2d_top ccr2d_checker u_ccr2d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.action       (action),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sum          (sum),
	.out_of_range (out_of_range)
);

// ===== dv/ccr2d_tb_pkg.sv =====
`timescale 1ns / 100ps
// Expected-sum tracker for the 2-D cross-correlation testbench: mirrors the
// kernel and image stores and the configuration registers, and checks each returned sum and register read.
// Depends on ccr2d_pkg.
package ccr2d_tb_pkg;
	import ccr2d_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [2:0] REG_SPARE  = 3'd7;

	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic                    oor;
	} ccr2d_sum_t;

	class ccr2d_sum_tracker;
		logic [SAMPLE_W-1:0] kernel_mem [DEF_MAX_KERNEL_SIDE*DEF_MAX_KERNEL_SIDE];
		logic [SAMPLE_W-1:0] image_mem [DEF_MAX_IMAGE_SIDE*DEF_MAX_IMAGE_SIDE];
		logic [IMG_CFG_W-1:0] image_rows;
		logic [IMG_CFG_W-1:0] image_cols;
		logic [KER_CFG_W-1:0] kernel_rows;
		logic [KER_CFG_W-1:0] kernel_cols;
		logic                 full_mode;
		ccr2d_sum_t           awaited_sums [$];
		int                   mismatches;

		function new();
			image_rows  = 6'd28;
			image_cols  = 6'd28;
			kernel_rows = 4'd3;
			kernel_cols = 4'd3;
			full_mode   = 1'b0;
			mismatches  = 0;
		endfunction

		function int clamp_side(int v, int top);
			return (v < 1) ? 1 : ((v > top) ? top : v);
		endfunction

		function void set_reg(logic [2:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
			REG_IMAGE_ROWS:  image_rows  = data[IMG_CFG_W-1:0];
			REG_IMAGE_COLS:  image_cols  = data[IMG_CFG_W-1:0];
			REG_KERNEL_ROWS: kernel_rows = data[KER_CFG_W-1:0];
			REG_KERNEL_COLS: kernel_cols = data[KER_CFG_W-1:0];
			REG_FULL_MODE:   full_mode   = data[0];
			default: ;
			endcase
		endfunction

		function void check_reg(logic [2:0] idx, logic [CFG_DW-1:0] data);
			logic [CFG_DW-1:0] held;
			case (idx)
			REG_IMAGE_ROWS:  held = CFG_DW'(image_rows);
			REG_IMAGE_COLS:  held = CFG_DW'(image_cols);
			REG_KERNEL_ROWS: held = CFG_DW'(kernel_rows);
			REG_KERNEL_COLS: held = CFG_DW'(kernel_cols);
			default:         held = CFG_DW'(full_mode);
			endcase
			if (data !== held) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: register %0d read %0h, expected %0h", $time, idx, data, held);
			end
		endfunction

		function void sizes(output int ir, output int ic, output int kr, output int kc,
				output int oh, output int ow);
			ir = clamp_side(int'(image_rows), DEF_MAX_IMAGE_SIDE);
			ic = clamp_side(int'(image_cols), DEF_MAX_IMAGE_SIDE);
			kr = clamp_side(int'(kernel_rows), DEF_MAX_KERNEL_SIDE);
			kc = clamp_side(int'(kernel_cols), DEF_MAX_KERNEL_SIDE);
			oh = full_mode ? ir + kr - 1 : ir - kr + 1;
			ow = full_mode ? ic + kc - 1 : ic - kc + 1;
		endfunction

		function void take_item(logic [1:0] act, logic [POS_IN_W-1:0] r,
				logic [POS_IN_W-1:0] c, logic [SAMPLE_W-1:0] v);
			int ir, ic, kr, kc, oh, ow, dr, dc, ri, ci, ii, jj;
			longint acc;
			ccr2d_sum_t res;
			sizes(ir, ic, kr, kc, oh, ow);
			ri = int'(r);
			ci = int'(c);
			case (act)
			ACT_KERNEL: begin
				if (ri < kr && ci < kc)
					kernel_mem[ri*DEF_MAX_KERNEL_SIDE + ci] = v;
			end
			ACT_IMAGE: begin
				if (ri < ir && ci < ic)
					image_mem[ri*DEF_MAX_IMAGE_SIDE + ci] = v;
			end
			ACT_REQUEST: begin
				res.sum = '0;
				res.oor = 1'b1;
				if (ri < oh && ci < ow) begin
					dr = full_mode ? kr - 1 : 0;
					dc = full_mode ? kc - 1 : 0;
					acc = 0;
					for (int a = 0; a < kr; a++) begin
						ii = ri + a - dr;
						if (ii < 0 || ii >= ir)
							continue;
						for (int b = 0; b < kc; b++) begin
							jj = ci + b - dc;
							if (jj < 0 || jj >= ic)
								continue;
							acc += longint'($signed(kernel_mem[a*DEF_MAX_KERNEL_SIDE + b])) *
								longint'($signed(image_mem[ii*DEF_MAX_IMAGE_SIDE + jj]));
						end
					end
					res.sum = acc[SUM_W-1:0];
					res.oor = 1'b0;
				end
				awaited_sums.push_back(res);
			end
			default: ;
			endcase
		endfunction

		function void check_sum(logic signed [SUM_W-1:0] s, logic oor);
			ccr2d_sum_t want;
			if (awaited_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected transfer, sum %0d oor %0b", $time, s, oor);
				return;
			end
			want = awaited_sums.pop_front();
			if (s !== want.sum || oor !== want.oor) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected sum %0d oor %0b, got sum %0d oor %0b",
						$time, want.sum, want.oor, s, oor);
			end
		endfunction

		function int pending();
			return awaited_sums.size();
		endfunction

		function bit failed();
			return mismatches != 0;
		endfunction
	endclass

endpackage

// ===== dv/cross_correlate_2d_top_test.sv =====
`timescale 1ns / 100ps
// Testbench top for cross_correlate_2d_top: fills the stores, runs directed and
// random items over many size and mode settings, checks every sum in order.
// Depends on ccr2d_pkg, ccr2d_tb_pkg and the block's RTL.
module cross_correlate_2d_top_test;
	import ccr2d_pkg::*;
	import ccr2d_tb_pkg::*;

	localparam int SETTLE_CYCLES = 80;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [1:0]                 action = ACT_KERNEL;
	logic [POS_IN_W-1:0]        row = '0;
	logic [POS_IN_W-1:0]        col = '0;
	logic signed [SAMPLE_W-1:0] value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SUM_W-1:0]    sum;
	logic                       out_of_range;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [CFG_AW-1:0]          paddr = '0;
	logic [CFG_DW-1:0]          pwdata = '0;
	logic [CFG_DW-1:0]          prdata;
	logic                       pready;

	bit quiet = 1'b0;
	int stall_left = 0;
	ccr2d_sum_tracker sb = new();

	cross_correlate_2d_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.row(row),
		.col(col),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum(sum),
		.out_of_range(out_of_range),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
	endfunction

	function automatic logic [SAMPLE_W-1:0] extreme_value();
		case ($urandom_range(0, 3))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'h0000;
		default: return 16'hFFFF;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_item(action, row, col, value);
			if (out_valid && !out_stall)
				sb.check_sum(sum, out_of_range);
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 25)
			stall_left = idle_len();
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(logic [1:0] act, int r, int c, logic [SAMPLE_W-1:0] v);
		int gap;
		gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		row <= POS_IN_W'(r);
		col <= POS_IN_W'(c);
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait out every awaited sum
	task automatic hold_input(bit settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [2:0] idx, logic [CFG_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr)
			sb.set_reg(idx, data);
		else
			sb.check_reg(idx, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int ir, int ic, int kr, int kc, int fm);
		hold_input(1'b1);
		apb_access(1'b1, REG_IMAGE_ROWS, CFG_DW'(ir));
		apb_access(1'b1, REG_IMAGE_COLS, CFG_DW'(ic));
		apb_access(1'b1, REG_KERNEL_ROWS, CFG_DW'(kr));
		apb_access(1'b1, REG_KERNEL_COLS, CFG_DW'(kc));
		apb_access(1'b1, REG_FULL_MODE, CFG_DW'(fm));
		apb_access(1'b0, REG_IMAGE_ROWS, '0);
		apb_access(1'b0, REG_IMAGE_COLS, '0);
		apb_access(1'b0, REG_KERNEL_ROWS, '0);
		apb_access(1'b0, REG_KERNEL_COLS, '0);
		apb_access(1'b0, REG_FULL_MODE, '0);
	endtask

	task automatic random_item();
		int ir, ic, kr, kc, oh, ow, pick, r, c;
		logic [1:0] act;
		logic [SAMPLE_W-1:0] v;
		sb.sizes(ir, ic, kr, kc, oh, ow);
		pick = $urandom_range(0, 99);
		v = ($urandom_range(0, 7) == 0) ? extreme_value() : SAMPLE_W'($urandom);
		r = $urandom_range(0, 63);
		c = $urandom_range(0, 63);
		if (pick < 45) begin
			act = ACT_REQUEST;
			if (oh > 0 && ow > 0 && $urandom_range(0, 7) != 0) begin
				r = $urandom_range(0, oh - 1);
				c = $urandom_range(0, ow - 1);
			end
		end else if (pick < 65) begin
			act = ACT_KERNEL;
			if ($urandom_range(0, 7) != 0) begin
				r = $urandom_range(0, kr - 1);
				c = $urandom_range(0, kc - 1);
			end
		end else if (pick < 95) begin
			act = ACT_IMAGE;
			if ($urandom_range(0, 7) != 0) begin
				r = $urandom_range(0, ir - 1);
				c = $urandom_range(0, ic - 1);
			end
		end else begin
			act = ACT_UNUSED;
		end
		send_item(act, r, c, v);
	endtask

	task automatic random_phase(int n, bit q);
		quiet = q;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				hold_input(1'b0);
			random_item();
		end
		quiet = 1'b0;
	endtask

	task automatic preload_stores();
		for (int r = 0; r < DEF_MAX_KERNEL_SIDE; r++)
			for (int c = 0; c < DEF_MAX_KERNEL_SIDE; c++)
				send_item(ACT_KERNEL, r, c, 16'h8000);
		for (int r = 0; r < DEF_MAX_IMAGE_SIDE; r++)
			for (int c = 0; c < DEF_MAX_IMAGE_SIDE; c++)
				send_item(ACT_IMAGE, r, c,
					(r < DEF_MAX_KERNEL_SIDE && c < DEF_MAX_KERNEL_SIDE) ?
					16'h8000 : SAMPLE_W'($urandom));
	endtask

	task automatic directed_items();
		send_item(ACT_REQUEST, 0, 0, 16'h0000);
		send_item(ACT_IMAGE, 0, 0, 16'h7FFF);
		send_item(ACT_REQUEST, 0, 0, 16'hFFFF);
		send_item(ACT_IMAGE, 31, 31, 16'h0001);
		send_item(ACT_KERNEL, 7, 7, 16'h7FFF);
		send_item(ACT_REQUEST, 24, 24, 16'h0000);
		send_item(ACT_REQUEST, 25, 0, 16'h0000);
		send_item(ACT_REQUEST, 0, 25, 16'h0000);
		send_item(ACT_REQUEST, 38, 38, 16'h0000);
		send_item(ACT_REQUEST, 63, 63, 16'h0000);
		send_item(ACT_KERNEL, 8, 0, 16'h1234);
		send_item(ACT_KERNEL, 0, 8, 16'h1234);
		send_item(ACT_IMAGE, 32, 0, 16'h1234);
		send_item(ACT_IMAGE, 0, 63, 16'h1234);
		send_item(ACT_UNUSED, 63, 63, 16'hFFFF);
		send_item(ACT_KERNEL, 0, 0, 16'h0000);
		send_item(ACT_IMAGE, 1, 1, 16'hFFFF);
		send_item(ACT_REQUEST, 0, 0, 16'h0000);
		send_item(ACT_REQUEST, 1, 1, 16'h0000);
		send_item(ACT_REQUEST, 63, 0, 16'h0000);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, REG_IMAGE_ROWS, '0);
		apb_access(1'b0, REG_IMAGE_COLS, '0);
		apb_access(1'b0, REG_KERNEL_ROWS, '0);
		apb_access(1'b0, REG_KERNEL_COLS, '0);
		apb_access(1'b0, REG_FULL_MODE, '0);
		apply_setting(32, 32, 8, 8, 0);
		apb_access(1'b1, REG_SPARE, 32'hFFFF_FFFF);
		preload_stores();
		directed_items();
		random_phase(80, 1'b0);
		apply_setting(32, 32, 8, 8, 1);
		send_item(ACT_REQUEST, 0, 0, 16'h0000);
		send_item(ACT_REQUEST, 38, 38, 16'h0000);
		send_item(ACT_REQUEST, 39, 0, 16'h0000);
		random_phase(80, 1'b0);
		apply_setting(1, 1, 1, 1, 0);
		random_phase(80, 1'b1);
		apply_setting(1, 1, 1, 1, 1);
		random_phase(80, 1'b0);
		apply_setting(2, 3, 8, 8, 0);
		random_phase(50, 1'b0);
		apply_setting(4, 4, 8, 2, 1);
		random_phase(80, 1'b0);
		apply_setting(0, 0, 0, 0, 0);
		random_phase(50, 1'b1);
		apply_setting(63, 63, 15, 15, 1);
		random_phase(80, 1'b0);
		apply_setting(28, 28, 3, 3, 0);
		random_phase(80, 1'b0);
		for (int p = 0; p < 4; p++) begin
			apply_setting($urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
			random_phase(80, p == 2);
		end
		hold_input(1'b1);
		if (sb.failed())
			$display("[cross_correlate_2d_top] ERROR");
		else
			$display("[cross_correlate_2d_top] OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[cross_correlate_2d_top] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ccr2d_pkg.sv
src/ccr2d_mac.sv
src/cross_correlate_2d_top.sv
src/ccr2d_checker.sv
dv/ccr2d_tb_pkg.sv
dv/cross_correlate_2d_top_test.sv
